### rtl/gps_pkg.sv
// Shared constants and types for the gait phase sampler.
package gps_pkg;

  localparam int ELAPSED_BITS_DEF  = 48;
  localparam int DURATION_BITS_DEF = 24;
  localparam int PROGRESS_BITS_DEF = 16;

  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_DOUBLE_SUPPORT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SWING          = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_LEG      = 2'd2;

  localparam logic [1:0] MODE_DOUBLE = 2'd0;
  localparam logic [1:0] MODE_LEFT   = 2'd1;
  localparam logic [1:0] MODE_RIGHT  = 2'd2;

  typedef struct packed {
    logic       ok;
    logic [1:0] mode;
    logic       has_swing;
    logic       swing;
    logic       phase;
  } seg_info_t;

endpackage

### rtl/gps_if.sv
// Handshake channels of the gait phase sampler: sample, result and configuration.
interface gps_in_if #(parameter int ELAPSED_BITS = gps_pkg::ELAPSED_BITS_DEF);
  logic                           valid;
  logic                           ready;
  logic signed [ELAPSED_BITS-1:0] elapsed_ticks;
  modport source (output valid, output elapsed_ticks, input ready);
  modport sink (input valid, input elapsed_ticks, output ready);
endinterface

interface gps_out_if #(parameter int PROGRESS_BITS = gps_pkg::PROGRESS_BITS_DEF);
  logic                     valid;
  logic                     ready;
  logic                     valid_res;
  logic [1:0]               support_mode;
  logic                     has_swing_leg;
  logic                     swing_side;
  logic                     phase_leg;
  logic [PROGRESS_BITS-1:0] segment_progress;
  modport source (output valid, output valid_res, output support_mode, output has_swing_leg,
                  output swing_side, output phase_leg, output segment_progress, input ready);
  modport sink (input valid, input valid_res, input support_mode, input has_swing_leg,
                input swing_side, input phase_leg, input segment_progress, output ready);
endinterface

interface gps_cfg_if #(parameter int DURATION_BITS = gps_pkg::DURATION_BITS_DEF);
  logic                                valid;
  logic                                ready;
  logic [gps_pkg::CFG_INDEX_BITS-1:0]  index;
  logic [DURATION_BITS-1:0]            data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/gps_mod_cell.sv
// One restoring step of the reduction of the sample modulo the gait cycle.
module gps_mod_cell #(
  parameter int ELAPSED_BITS = gps_pkg::ELAPSED_BITS_DEF,
  parameter int CYCLE_BITS   = gps_pkg::DURATION_BITS_DEF + 2
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  logic [CYCLE_BITS-1:0]   cycle,
  input  logic                    v_in,
  input  logic [CYCLE_BITS-1:0]   rem_in,
  input  logic [ELAPSED_BITS-1:0] dv_in,
  output logic                    v_out,
  output logic [CYCLE_BITS-1:0]   rem_out,
  output logic [ELAPSED_BITS-1:0] dv_out
);

  logic [CYCLE_BITS:0]   trial;
  logic [CYCLE_BITS-1:0] rem_next;

  always_comb begin
    trial = {rem_in, dv_in[ELAPSED_BITS-1]};
    if (trial >= {1'b0, cycle}) begin
      rem_next = CYCLE_BITS'(trial - {1'b0, cycle});
    end else begin
      rem_next = trial[CYCLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (adv) begin
      v_out <= v_in;
    end
    if (adv) begin
      rem_out <= rem_next;
      dv_out  <= {dv_in[ELAPSED_BITS-2:0], 1'b0};
    end
  end

endmodule

### rtl/gps_segment.sv
// Picks the gait segment of the reduced time and its offset and length.
module gps_segment #(
  parameter int DURATION_BITS = gps_pkg::DURATION_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic [DURATION_BITS-1:0]   ds,
  input  logic [DURATION_BITS-1:0]   sw,
  input  logic                       first,
  input  logic                       v_in,
  input  logic [DURATION_BITS+1:0]   t_in,
  output logic                       v_out,
  output logic [DURATION_BITS-1:0]   off_out,
  output logic [DURATION_BITS-1:0]   dur_out,
  output gps_pkg::seg_info_t         info_out
);

  logic [DURATION_BITS+1:0] ds_x, b1, b2;
  logic [DURATION_BITS-1:0] off_next, dur_next;
  gps_pkg::seg_info_t       info_next;
  logic                     second;

  always_comb begin
    second = ~first;
    ds_x   = (DURATION_BITS+2)'(ds);
    b1     = ds_x + (DURATION_BITS+2)'(sw);
    b2     = b1 + ds_x;
    info_next.ok = (ds != '0) && (sw != '0);
    if (t_in < ds_x) begin
      off_next             = DURATION_BITS'(t_in);
      dur_next             = ds;
      info_next.mode       = gps_pkg::MODE_DOUBLE;
      info_next.has_swing  = 1'b0;
      info_next.swing      = 1'b0;
      info_next.phase      = first;
    end else if (t_in < b1) begin
      off_next             = DURATION_BITS'(t_in - ds_x);
      dur_next             = sw;
      info_next.mode       = first ? gps_pkg::MODE_LEFT : gps_pkg::MODE_RIGHT;
      info_next.has_swing  = 1'b1;
      info_next.swing      = first;
      info_next.phase      = first;
    end else if (t_in < b2) begin
      off_next             = DURATION_BITS'(t_in - b1);
      dur_next             = ds;
      info_next.mode       = gps_pkg::MODE_DOUBLE;
      info_next.has_swing  = 1'b0;
      info_next.swing      = 1'b0;
      info_next.phase      = second;
    end else begin
      off_next             = DURATION_BITS'(t_in - b2);
      dur_next             = sw;
      info_next.mode       = second ? gps_pkg::MODE_LEFT : gps_pkg::MODE_RIGHT;
      info_next.has_swing  = 1'b1;
      info_next.swing      = second;
      info_next.phase      = second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (adv) begin
      v_out <= v_in;
    end
    if (adv) begin
      off_out  <= off_next;
      dur_out  <= dur_next;
      info_out <= info_next;
    end
  end

endmodule

### rtl/gps_frac_cell.sv
// One restoring step of the progress fraction, one quotient bit per cell.
module gps_frac_cell #(
  parameter int DURATION_BITS = gps_pkg::DURATION_BITS_DEF,
  parameter int PROGRESS_BITS = gps_pkg::PROGRESS_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic                     v_in,
  input  logic [DURATION_BITS-1:0] rem_in,
  input  logic [DURATION_BITS-1:0] dur_in,
  input  logic [PROGRESS_BITS-1:0] q_in,
  input  gps_pkg::seg_info_t       info_in,
  output logic                     v_out,
  output logic [DURATION_BITS-1:0] rem_out,
  output logic [DURATION_BITS-1:0] dur_out,
  output logic [PROGRESS_BITS-1:0] q_out,
  output gps_pkg::seg_info_t       info_out
);

  logic [DURATION_BITS:0]   trial;
  logic                     ge;
  logic [DURATION_BITS-1:0] rem_next;

  always_comb begin
    trial = {rem_in, 1'b0};
    ge    = trial >= {1'b0, dur_in};
    if (ge) begin
      rem_next = DURATION_BITS'(trial - {1'b0, dur_in});
    end else begin
      rem_next = trial[DURATION_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (adv) begin
      v_out <= v_in;
    end
    if (adv) begin
      rem_out  <= rem_next;
      dur_out  <= dur_in;
      q_out    <= {q_in[PROGRESS_BITS-2:0], ge};
      info_out <= info_in;
    end
  end

endmodule

### rtl/gait_phase_sampler.sv
// Gait phase sampler: cycle reduction and progress division as chains of cells.
// Usage notes.
// The sample channel takes one signed elapsed time in ticks per request; the
// result channel returns one request per sample, in order, carrying the
// validity flag, support mode, swing leg, phase leg and Q0.16 progress.
// Configuration writes (double support, swing, first leg) arrive on the
// configuration channel, which is always ready; write only while idle.
// Throughput: one sample per cycle while the receiver takes results. A sample
// passes through one modulo cell per remainder bit, then the segment stage,
// then one progress cell per quotient bit.
// The whole chain advances together; when the receiver stalls with a result
// waiting, every cell holds and sample ready drops in the same cycle, so no
// request is lost. The last cell's registers are the output register.
// Reset clears the configuration registers to zero and empties the chain;
// with a zero duration every result reports invalid with all fields zero.
module gait_phase_sampler #(
  parameter int ELAPSED_BITS  = gps_pkg::ELAPSED_BITS_DEF,
  parameter int DURATION_BITS = gps_pkg::DURATION_BITS_DEF,
  parameter int PROGRESS_BITS = gps_pkg::PROGRESS_BITS_DEF
) (
  input logic   clk,
  input logic   rst,
  gps_in_if.sink   sample,
  gps_out_if.source result,
  gps_cfg_if.sink  cfg
);

  localparam int CYCLE_BITS = DURATION_BITS + 2;

  logic [DURATION_BITS-1:0] ds, sw;
  logic                     first;
  logic [CYCLE_BITS-1:0]    cycle;
  logic                     adv;

  assign adv          = !result.valid || result.ready;
  assign sample.ready = adv;
  assign cfg.ready    = 1'b1;
  assign cycle        = CYCLE_BITS'({(DURATION_BITS+1)'(ds) + (DURATION_BITS+1)'(sw), 1'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      ds    <= '0;
      sw    <= '0;
      first <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        gps_pkg::REG_DOUBLE_SUPPORT: ds    <= cfg.data;
        gps_pkg::REG_SWING:          sw    <= cfg.data;
        gps_pkg::REG_FIRST_LEG:      first <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Modulo chain.
  logic                    mv   [ELAPSED_BITS+1];
  logic [CYCLE_BITS-1:0]   mrem [ELAPSED_BITS+1];
  logic [ELAPSED_BITS-1:0] mdv  [ELAPSED_BITS+1];

  assign mv[0]   = sample.valid;
  assign mrem[0] = '0;
  assign mdv[0]  = sample.elapsed_ticks[ELAPSED_BITS-1] ? '0 : sample.elapsed_ticks;

  for (genvar i = 0; i < ELAPSED_BITS; i++) begin : g_mod
    gps_mod_cell #(.ELAPSED_BITS(ELAPSED_BITS), .CYCLE_BITS(CYCLE_BITS)) u_cell (
      .clk(clk), .rst(rst), .adv(adv), .cycle(cycle),
      .v_in(mv[i]), .rem_in(mrem[i]), .dv_in(mdv[i]),
      .v_out(mv[i+1]), .rem_out(mrem[i+1]), .dv_out(mdv[i+1])
    );
  end

  // Progress chain, fed by the segment stage.
  logic                     fv    [PROGRESS_BITS+1];
  logic [DURATION_BITS-1:0] frem  [PROGRESS_BITS+1];
  logic [DURATION_BITS-1:0] fdur  [PROGRESS_BITS+1];
  logic [PROGRESS_BITS-1:0] fq    [PROGRESS_BITS+1];
  gps_pkg::seg_info_t       finfo [PROGRESS_BITS+1];

  gps_segment #(.DURATION_BITS(DURATION_BITS)) u_segment (
    .clk(clk), .rst(rst), .adv(adv), .ds(ds), .sw(sw), .first(first),
    .v_in(mv[ELAPSED_BITS]), .t_in(mrem[ELAPSED_BITS]),
    .v_out(fv[0]), .off_out(frem[0]), .dur_out(fdur[0]), .info_out(finfo[0])
  );
  assign fq[0] = '0;

  for (genvar k = 0; k < PROGRESS_BITS; k++) begin : g_frac
    gps_frac_cell #(.DURATION_BITS(DURATION_BITS), .PROGRESS_BITS(PROGRESS_BITS)) u_cell (
      .clk(clk), .rst(rst), .adv(adv),
      .v_in(fv[k]), .rem_in(frem[k]), .dur_in(fdur[k]), .q_in(fq[k]), .info_in(finfo[k]),
      .v_out(fv[k+1]), .rem_out(frem[k+1]), .dur_out(fdur[k+1]), .q_out(fq[k+1]),
      .info_out(finfo[k+1])
    );
  end

  gps_pkg::seg_info_t last;
  logic               ok;
  assign last = finfo[PROGRESS_BITS];
  assign ok   = last.ok;

  // An invalid timing forces every field to zero.
  assign result.valid            = fv[PROGRESS_BITS];
  assign result.valid_res        = ok;
  assign result.support_mode     = ok ? last.mode : gps_pkg::MODE_DOUBLE;
  assign result.has_swing_leg    = ok & last.has_swing;
  assign result.swing_side       = ok & last.swing;
  assign result.phase_leg        = ok & last.phase;
  assign result.segment_progress = ok ? fq[PROGRESS_BITS] : '0;

`ifndef SYNTHESIS
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.valid_res |-> result.segment_progress == '0 &&
      result.support_mode == gps_pkg::MODE_DOUBLE && !result.phase_leg)
    else $error("invalid result carries nonzero fields");
  a_swing_mode: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.has_swing_leg |->
      result.support_mode == (result.swing_side ? gps_pkg::MODE_LEFT : gps_pkg::MODE_RIGHT))
    else $error("support mode disagrees with swing leg");
  a_double_no_swing: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.has_swing_leg |->
      !result.swing_side && result.support_mode == gps_pkg::MODE_DOUBLE)
    else $error("double support reports a swing leg");
  a_stall_holds_chain: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> $stable(fq[PROGRESS_BITS]) && result.valid)
    else $error("chain moved during a stall");
`endif

endmodule

### verif/gps_tb_if.sv
`timescale 1ns / 100ps
// Testbench constants for the gait phase sampler.
package gps_tb_pkg;
  localparam int CYCLE_WATCHDOG = 5000;
endpackage

### verif/testbench.sv
`timescale 1ns / 100ps
// Testbench for the gait phase sampler: random samples against a local phase predictor.
module testbench;

  typedef struct packed {
    logic       ok;
    logic [1:0] mode;
    logic       has_swing;
    logic       swing;
    logic       phase;
    logic [15:0] progress;
  } phase_t;

  logic clk, rst;
  gps_in_if  sample_ch();
  gps_out_if result_ch();
  gps_cfg_if cfg_ch();

  gait_phase_sampler dut (.clk(clk), .rst(rst), .sample(sample_ch), .result(result_ch),
                          .cfg(cfg_ch));

  logic [23:0] ds_len, sw_len;
  logic        lead_leg;
  logic signed [47:0] pending_samples[$];
  phase_t      expected_phases[$];
  int          mismatches, idle_cycles, send_wait, recv_wait;
  bit          timed_out, in_taken, stall_go, long_stall;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] fraction(logic [63:0] t, logic [63:0] d);
    logic [63:0] q;
    q = (t << 16) / d;
    return q[15:0];
  endfunction

  function automatic phase_t predict_phase(logic signed [47:0] sample);
    phase_t p;
    logic [63:0] t, cyc;
    logic        second;
    p = '0;
    if (ds_len == 0 || sw_len == 0) return p;
    second = ~lead_leg;
    t = sample < 0 ? 64'd0 : 64'(sample);
    cyc = 2 * (64'(ds_len) + 64'(sw_len));
    t = t % cyc;
    p.ok = 1;
    if (t < ds_len) begin
      p.phase = lead_leg;
      p.progress = fraction(t, ds_len);
      return p;
    end
    t -= ds_len;
    if (t < sw_len) begin
      p.mode = lead_leg ? gps_pkg::MODE_LEFT : gps_pkg::MODE_RIGHT;
      p.has_swing = 1;
      p.swing = lead_leg;
      p.phase = lead_leg;
      p.progress = fraction(t, sw_len);
      return p;
    end
    t -= sw_len;
    if (t < ds_len) begin
      p.phase = second;
      p.progress = fraction(t, ds_len);
      return p;
    end
    t -= ds_len;
    p.mode = second ? gps_pkg::MODE_LEFT : gps_pkg::MODE_RIGHT;
    p.has_swing = 1;
    p.swing = second;
    p.phase = second;
    p.progress = fraction(t, sw_len);
    return p;
  endfunction

  // Sample driver: one request at a time, with a random gap before each.
  always @(negedge clk) begin
    if (rst) begin
      sample_ch.valid <= 0;
      send_wait <= 0;
    end else if (sample_ch.valid && !in_taken) begin
    end else if (send_wait > 0) begin
      sample_ch.valid <= 0;
      send_wait <= send_wait - 1;
    end else if (pending_samples.size() > 0) begin
      sample_ch.valid <= 1;
      sample_ch.elapsed_ticks <= pending_samples.pop_front();
      send_wait <= $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0;
    end else begin
      sample_ch.valid <= 0;
    end
  end

  // Expectations are formed when the sample is accepted.
  always @(posedge clk) begin
    in_taken <= !rst && sample_ch.valid && sample_ch.ready;
    if (!rst && sample_ch.valid && sample_ch.ready)
      expected_phases.push_back(predict_phase(sample_ch.elapsed_ticks));
  end

  // Long receiver hold-off, counted here once the main sequence asks for it.
  initial begin
    long_stall = 0;
    wait (stall_go);
    @(posedge clk);
    long_stall <= 1;
    repeat (300) @(posedge clk);
    long_stall <= 0;
  end

  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 0;
      recv_wait <= 0;
    end else if (long_stall) begin
      result_ch.ready <= 0;
    end else if (recv_wait > 0) begin
      result_ch.ready <= 0;
      recv_wait <= recv_wait - 1;
    end else begin
      result_ch.ready <= 1;
      recv_wait <= $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0;
    end
  end

  always @(posedge clk) begin
    phase_t got, want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = {result_ch.valid_res, result_ch.support_mode, result_ch.has_swing_leg,
             result_ch.swing_side, result_ch.phase_leg, result_ch.segment_progress};
      if (expected_phases.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", got);
      end else begin
        want = expected_phases.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Mismatch: expected ok=%0d mode=%0d sw=%0d/%0d ph=%0d prog=%0d, ",
                      "got ok=%0d mode=%0d sw=%0d/%0d ph=%0d prog=%0d"},
                     want.ok, want.mode, want.has_swing, want.swing, want.phase,
                     want.progress, got.ok, got.mode, got.has_swing, got.swing,
                     got.phase, got.progress);
        end
      end
    end
  end

  // Watchdog on cycles in which no request moves on any channel.
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= gps_tb_pkg::CYCLE_WATCHDOG && !timed_out) begin
      timed_out = 1;
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(logic [gps_pkg::CFG_INDEX_BITS-1:0] idx, logic [23:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 0;
    case (idx)
      gps_pkg::REG_DOUBLE_SUPPORT: ds_len = value;
      gps_pkg::REG_SWING:          sw_len = value;
      gps_pkg::REG_FIRST_LEG:      lead_leg = value[0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_samples.size() > 0 || expected_phases.size() > 0 || sample_ch.valid)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic signed [47:0] rand_sample(logic [23:0] ds, logic [23:0] sw);
    logic [63:0] cyc;
    logic [47:0] v;
    cyc = 2 * (64'(ds) + 64'(sw));
    case ($urandom_range(0, 5))
      0: v = 48'({$urandom, $urandom});
      1: v = -48'sd1 - 48'($urandom_range(0, 1000));
      2: v = 48'(cyc) * $urandom_range(0, 2000) + $urandom_range(0, 3) - 2;
      default: v = cyc == 0 ? 48'({$urandom, $urandom})
                            : 48'({$urandom, $urandom} % (cyc * 8));
    endcase
    return v;
  endfunction

  initial begin
    logic [23:0] ds_set[7] = '{24'd1, 24'hFFFFFF, 24'd5, 24'd1, 24'd100, 24'd37, 24'd0};
    logic [23:0] sw_set[7] = '{24'd1, 24'hFFFFFF, 24'd3, 24'hFFFFFF, 24'd1, 24'd1234, 24'd9};
    rst = 1;
    stall_go = 0;
    cfg_ch.valid = 0; cfg_ch.index = '0; cfg_ch.data = '0;
    ds_len = 0; sw_len = 0; lead_leg = 0;
    repeat (12) @(posedge clk);
    rst = 0;
    // Directed: invalid timing after reset, then field extremes.
    foreach (ds_set[k]) if (k == 0) begin
      pending_samples.push_back(48'sd0);
      pending_samples.push_back(48'sh7FFFFFFFFFFF);
      pending_samples.push_back(48'sh800000000000);
    end
    drain();
    write_reg(gps_pkg::REG_DOUBLE_SUPPORT, 24'd10);
    write_reg(gps_pkg::REG_SWING, 24'd20);
    write_reg(gps_pkg::REG_FIRST_LEG, 24'd0);
    for (int t = 0; t < 60; t += 5) pending_samples.push_back(48'(t));
    pending_samples.push_back(48'sh7FFFFFFFFFFF);
    pending_samples.push_back(48'sh800000000000);
    pending_samples.push_back(-48'sd1);
    pending_samples.push_back(48'sd59);
    drain();
    // Long receiver stall while samples keep coming, to fill the pipeline.
    for (int n = 0; n < 100; n++) pending_samples.push_back(rand_sample(ds_len, sw_len));
    stall_go = 1;
    drain();
    foreach (ds_set[k]) begin
      write_reg(gps_pkg::REG_DOUBLE_SUPPORT, ds_set[k]);
      write_reg(gps_pkg::REG_SWING, sw_set[k]);
      write_reg(gps_pkg::REG_FIRST_LEG, 24'(k % 2));
      for (int n = 0; n < 90; n++) pending_samples.push_back(rand_sample(ds_set[k], sw_set[k]));
      drain();
    end
    if (mismatches == 0 && expected_phases.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
